### sv/npps_pkg.sv
// Shared types and request codes for the nonpreemptive priority scheduler.
package npps_pkg;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] arrival;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

### sv/npps_cell.sv
// One cell of the sorted ready chain: holds a job, shifts on insert and pop.
module npps_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npps_pkg::t_cell_ctl i_ctl,
    input  npps_pkg::t_job    i_new,
    input  npps_pkg::t_slot   i_left,
    input  logic              i_left_nb,
    input  npps_pkg::t_slot   i_right,
    output npps_pkg::t_slot   o_slot,
    output logic              o_nb
);
    import npps_pkg::*;

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;

    assign o_nb   = !r_valid || (i_new.prio < r_job.prio);
    assign o_slot = '{valid: r_valid, job: r_job};

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (i_ctl.ins) begin
            if (i_left_nb) begin
                n_valid = i_left.valid;
                n_job   = i_left.job;
            end else if (o_nb) begin
                n_valid = 1'b1;
                n_job   = i_new;
            end
        end else if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_job   = i_right.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

### sv/nonpreemptive_priority_scheduler_top.sv
// Nonpreemptive priority scheduler: sorted cell chain, running job and result register.
// A result is registered and valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled; the output register stalls input when full and i_stall is high.
// The chain keeps the best job at its head, so dispatch and insert need no search.
// Reset (synchronous, active low) clears chain valid bits, running job and clock.
// No clearing pass is needed; the block accepts transactions right after reset.
module nonpreemptive_priority_scheduler_top #(
    parameter int READY_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_job_id,
    input  logic [7:0]  i_job_priority,
    input  logic [15:0] i_job_burst,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_rejected,
    output logic        o_busy_res,
    output logic [7:0]  o_running_id,
    output logic        o_started,
    output logic        o_completed,
    output logic [31:0] o_response_time,
    output logic [31:0] o_turnaround_time,
    output logic [31:0] o_wait_time,
    output logic [31:0] o_now_time
);
    import npps_pkg::*;

    t_slot            w_slot [READY_SLOTS];
    t_slot            w_lin  [READY_SLOTS];
    t_slot            w_rin  [READY_SLOTS];
    logic             w_nb   [READY_SLOTS];
    logic             w_lnb  [READY_SLOTS];
    logic [READY_SLOTS-1:0] w_valid_vec;
    t_cell_ctl        w_ctl;
    t_job             w_new;

    logic        r_run_valid;
    logic [15:0] r_run_left;
    t_job        r_run_job;
    logic [31:0] r_now;

    logic        r_out_valid;
    logic        r_rejected;
    logic        r_busy;
    logic [7:0]  r_rid;
    logic        r_started;
    logic        r_completed;
    logic [31:0] r_resp;
    logic [31:0] r_turn;
    logic [31:0] r_wait;
    logic [31:0] r_now_out;

    logic        w_acc;
    logic        w_tick;
    logic        w_full;
    logic        w_disp;
    logic        w_active;
    logic        w_done;
    t_job        w_cur;
    logic [15:0] w_cur_left;
    logic [31:0] w_resp;
    logic [31:0] w_turn;
    logic [31:0] w_wait;

    assign o_stall = r_out_valid && i_stall;
    assign w_acc   = i_valid && !o_stall;
    assign w_tick  = (i_req_type == REQ_TICK);
    assign w_full  = w_slot[READY_SLOTS-1].valid;

    assign w_new = '{id: i_job_id, prio: i_job_priority, burst: i_job_burst, arrival: r_now};

    assign w_disp     = !r_run_valid && w_slot[0].valid;
    assign w_active   = r_run_valid || w_disp;
    assign w_cur      = w_disp ? w_slot[0].job : r_run_job;
    assign w_cur_left = w_disp ? w_slot[0].job.burst : r_run_left;
    assign w_done     = w_active && (w_cur_left <= 16'd1);
    assign w_resp     = r_now - w_slot[0].job.arrival;
    assign w_turn     = r_now + 32'd1 - w_cur.arrival;
    assign w_wait     = w_turn - {16'd0, w_cur.burst};

    assign w_ctl.ins = w_acc && (i_req_type == REQ_ARRIVAL) && !w_full;
    assign w_ctl.pop = w_acc && w_tick && w_disp;

    for (genvar g = 0; g < READY_SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_lin[g] = '0;
            assign w_lnb[g] = 1'b0;
        end else begin : g_mid
            assign w_lin[g] = w_slot[g-1];
            assign w_lnb[g] = w_nb[g-1];
        end
        if (g == READY_SLOTS - 1) begin : g_last
            assign w_rin[g] = '0;
        end else begin : g_inner
            assign w_rin[g] = w_slot[g+1];
        end
        assign w_valid_vec[g] = w_slot[g].valid;

        npps_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_left    (w_lin[g]),
            .i_left_nb (w_lnb[g]),
            .i_right   (w_rin[g]),
            .o_slot    (w_slot[g]),
            .o_nb      (w_nb[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_left  <= '0;
            r_run_job   <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc && w_tick) begin
                r_now <= r_now + 32'd1;
                if (w_active) begin
                    r_run_job <= w_cur;
                    if (w_done) begin
                        r_run_valid <= 1'b0;
                        r_run_left  <= '0;
                    end else begin
                        r_run_valid <= 1'b1;
                        r_run_left  <= w_cur_left - 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_now_out   <= r_now;
            r_rejected  <= !w_tick && w_full;
            r_busy      <= w_tick && w_active;
            r_rid       <= (w_tick && w_active) ? w_cur.id : 8'd0;
            r_started   <= w_tick && w_disp;
            r_completed <= w_tick && w_done;
            r_resp      <= (w_tick && w_disp) ? w_resp : 32'd0;
            r_turn      <= (w_tick && w_done) ? w_turn : 32'd0;
            r_wait      <= (w_tick && w_done) ? w_wait : 32'd0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_rejected        = r_rejected;
    assign o_busy_res        = r_busy;
    assign o_running_id      = r_rid;
    assign o_started         = r_started;
    assign o_completed       = r_completed;
    assign o_response_time   = r_resp;
    assign o_turnaround_time = r_turn;
    assign o_wait_time       = r_wait;
    assign o_now_time        = r_now_out;

`ifndef SYNTHESIS
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("ready chain has a hole");

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot[1].valid |-> (w_slot[0].job.prio <= w_slot[1].job.prio))
        else $error("ready chain head out of order");

    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_run_left != 16'd0))
        else $error("running job with no time left");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req_type == REQ_ARRIVAL) && w_full) |=> (o_valid && o_rejected))
        else $error("arrival to full chain not rejected");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_completed) |-> o_busy_res)
        else $error("completion without a running job");
`endif

endmodule
